@@ rtl/core/fbca_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Block chain allocator package
// Shared codes, micro-operations and the status bundle between the
// controller and the datapath.
// ---------------------------------------------------------------------------
package fbca_pkg;

    localparam logic [1:0] CMD_CREATE = 2'd0;
    localparam logic [1:0] CMD_RESIZE = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NO_SLOT  = 2'd1;
    localparam logic [1:0] ST_NO_SPACE = 2'd2;

    localparam logic [3:0] LG_MAX   = 4'd12;
    localparam logic [3:0] LG_RESET = 4'd9;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LATCH,
        OP_SCAN_NEXT,
        OP_CLAIM,
        OP_NOSLOT,
        OP_EVAL,
        OP_REL_INIT,
        OP_REL_STEP,
        OP_WALK_GROW,
        OP_WALK_CUT,
        OP_WALK_STEP,
        OP_CUT,
        OP_ALC_INIT,
        OP_ALC_RD,
        OP_ALC_STEP,
        OP_REJECT,
        OP_FIN_LEN,
        OP_FIN_SHR0,
        OP_FIN_DEL
    } t_op;

    typedef struct packed {
        logic [1:0] cmd;
        logic       slot_ok;
        logic       kind_zero;
        logic       fptr_last;
        logic       grow;
        logic       shrink;
        logic       oldc_zero;
        logic       newc_zero;
        logic       too_short;
        logic       cnt_zero;
        logic       busy;
        logic       need_one;
        logic       bptr_last;
        logic       clr_last;
    } t_dp_sts;

endpackage
`default_nettype wire

@@ rtl/core/fbca_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one allocator request per transfer.
// ---------------------------------------------------------------------------
interface fbca_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [5:0]  file_slot;
    logic [23:0] req_bytes;
    logic [1:0]  req_kind;

    modport source (output valid, command, file_slot, req_bytes, req_kind, input ready);
    modport sink   (input valid, command, file_slot, req_bytes, req_kind, output ready);
endinterface
`default_nettype wire

@@ rtl/core/fbca_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result per transfer.
// ---------------------------------------------------------------------------
interface fbca_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [5:0] created_slot;
    logic [8:0] free_count;

    modport source (output valid, status, created_slot, free_count, input ready);
    modport sink   (input valid, status, created_slot, free_count, output ready);
endinterface
`default_nettype wire

@@ rtl/core/file_block_chain_allocator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// File block chain allocator
// File table with linked block chains over a free-block bitmap.
// ---------------------------------------------------------------------------
// After reset the unit runs a clearing pass over max(NUM_BLOCKS, NUM_FILES)
// entries of the bitmap and the file kinds, during which no request is taken.
// Requests are then handled one at a time and each gives one response. A
// create scans the file slots in turn for a free one. A resize or delete
// walks the chain, releases blocks or examines the bitmap block by block,
// each step being one read of the block memories. The next request is taken
// once the response has been transferred.
module file_block_chain_allocator_unit #(
    parameter int NUM_BLOCKS = 256,
    parameter int NUM_FILES  = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire [3:0]   i_cfg_wr_data,
    fbca_req_if.sink    i_req,
    fbca_rsp_if.source  o_rsp
);
    import fbca_pkg::*;

    t_op     w_op;
    t_dp_sts w_sts;

    fbca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (w_sts),
        .o_op        (w_op)
    );

    fbca_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .NUM_FILES  (NUM_FILES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_command      (i_req.command),
        .i_file_slot    (i_req.file_slot),
        .i_req_bytes    (i_req.req_bytes),
        .i_req_kind     (i_req.req_kind),
        .i_op           (w_op),
        .o_sts          (w_sts),
        .o_status       (o_rsp.status),
        .o_created_slot (o_rsp.created_slot),
        .o_free_count   (o_rsp.free_count)
    );

endmodule
`default_nettype wire

@@ rtl/core/fbca_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Block chain allocator datapath
// File table, block bitmap and link memories with the cursors and counters
// that the controller steps through them.
// ---------------------------------------------------------------------------
module fbca_datapath #(
    parameter int NUM_BLOCKS = 256,
    parameter int NUM_FILES  = 64
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_wr_en,
    input  wire [3:0]        i_cfg_wr_data,
    input  wire [1:0]        i_command,
    input  wire [5:0]        i_file_slot,
    input  wire [23:0]       i_req_bytes,
    input  wire [1:0]        i_req_kind,
    input  fbca_pkg::t_op    i_op,
    output fbca_pkg::t_dp_sts o_sts,
    output logic [1:0]       o_status,
    output logic [5:0]       o_created_slot,
    output logic [8:0]       o_free_count
);
    import fbca_pkg::*;

    localparam int BW   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int FW   = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;
    localparam int CW   = $clog2(NUM_BLOCKS + 1);
    localparam int MAXN = (NUM_BLOCKS > NUM_FILES) ? NUM_BLOCKS : NUM_FILES;
    localparam int CLW  = (MAXN > 1) ? $clog2(MAXN) : 1;

    logic            busy_mem [NUM_BLOCKS];
    logic [BW-1:0]   link_mem [NUM_BLOCKS];
    logic [1:0]      kind_mem [NUM_FILES];
    logic [23:0]     len_mem  [NUM_FILES];
    logic [BW-1:0]   head_mem [NUM_FILES];

    logic [1:0]    r_cmd;
    logic [5:0]    r_slot;
    logic [23:0]   r_size;
    logic [1:0]    r_kind;
    logic [3:0]    r_lg;
    logic [CW-1:0] r_free;
    logic [1:0]    r_status;
    logic [5:0]    r_created;
    logic [FW-1:0] r_fptr;
    logic [BW-1:0] r_bptr;
    logic [BW-1:0] r_blk;
    logic [BW-1:0] r_tail;
    logic          r_has_tail;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_need;
    logic [24:0]   r_oldc;
    logic [24:0]   r_newc;
    logic [BW-1:0] r_head;
    logic [CLW-1:0] r_ccnt;

    logic [1:0]    r_rd_kind;
    logic [23:0]   r_rd_len;
    logic [BW-1:0] r_rd_head;
    logic          r_rd_busy;
    logic [BW-1:0] r_rd_link;

    logic [FW+5:0]  w_slot_ext;
    logic [FW+5:0]  w_fptr_ext;
    logic [FW-1:0]  w_faddr;
    logic [BW-1:0]  w_baddr;
    logic [24:0]    w_oldc;
    logic [24:0]    w_newc;
    logic [CW+8:0]  w_free_ext;

    logic          w_busy_we;
    logic [BW-1:0] w_busy_wa;
    logic          w_busy_wd;
    logic          w_link_we;
    logic          w_kind_we;
    logic [FW-1:0] w_kind_wa;
    logic [1:0]    w_kind_wd;
    logic          w_head_we;
    logic [BW-1:0] w_head_wd;
    logic          w_len_we;
    logic [23:0]   w_len_wd;

    function automatic logic [24:0] blocks_for(input logic [23:0] sz, input logic [3:0] lg);
        logic [3:0]  l;
        logic [24:0] m;
        l = (lg > LG_MAX) ? LG_MAX : lg;
        m = (25'd1 << l) - 25'd1;
        return (25'(sz) + m) >> l;
    endfunction

    function automatic logic [CW-1:0] cap(input logic [24:0] x);
        if (32'(x) > NUM_BLOCKS) begin
            return CW'(NUM_BLOCKS);
        end
        return x[CW-1:0];
    endfunction

    assign w_slot_ext = (FW + 6)'(r_slot);
    assign w_fptr_ext = (FW + 6)'(r_fptr);
    assign w_faddr    = (r_cmd == CMD_CREATE) ? r_fptr : w_slot_ext[FW-1:0];
    assign w_baddr    = (i_op == OP_ALC_RD) ? r_bptr : r_blk;
    assign w_oldc     = blocks_for(r_rd_len, r_lg);
    assign w_newc     = blocks_for(r_size, r_lg);
    assign w_free_ext = (CW + 9)'(r_free);

    always_comb begin
        w_busy_we = 1'b0;
        w_busy_wa = r_blk;
        w_busy_wd = 1'b0;
        w_link_we = 1'b0;
        w_kind_we = 1'b0;
        w_kind_wa = w_faddr;
        w_kind_wd = 2'd0;
        w_head_we = 1'b0;
        w_head_wd = '0;
        w_len_we  = 1'b0;
        w_len_wd  = r_size;
        case (i_op)
            OP_CLEAR: begin
                w_busy_we = (32'(r_ccnt) < NUM_BLOCKS);
                w_busy_wa = r_ccnt[BW-1:0];
                w_kind_we = (32'(r_ccnt) < NUM_FILES);
                w_kind_wa = r_ccnt[FW-1:0];
            end
            OP_CLAIM: begin
                w_kind_we = 1'b1;
                w_kind_wd = r_kind;
                w_head_we = 1'b1;
                w_len_we  = 1'b1;
                w_len_wd  = 24'd0;
            end
            OP_REL_STEP: begin
                w_busy_we = r_rd_busy;
            end
            OP_ALC_STEP: begin
                w_busy_we = !r_rd_busy;
                w_busy_wa = r_bptr;
                w_busy_wd = 1'b1;
                w_link_we = !r_rd_busy && r_has_tail;
                w_head_we = !r_rd_busy && !r_has_tail;
                w_head_wd = r_bptr;
            end
            OP_FIN_LEN: begin
                w_len_we = 1'b1;
            end
            OP_FIN_SHR0: begin
                w_len_we  = 1'b1;
                w_head_we = 1'b1;
            end
            OP_FIN_DEL: begin
                w_kind_we = 1'b1;
                w_head_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_busy_we) begin
            busy_mem[w_busy_wa] <= w_busy_wd;
        end
        if (w_link_we) begin
            link_mem[r_tail] <= r_bptr;
        end
        if (w_kind_we) begin
            kind_mem[w_kind_wa] <= w_kind_wd;
        end
        if (w_head_we) begin
            head_mem[w_faddr] <= w_head_wd;
        end
        if (w_len_we) begin
            len_mem[w_faddr] <= w_len_wd;
        end
        r_rd_busy <= busy_mem[w_baddr];
        r_rd_link <= link_mem[w_baddr];
        r_rd_kind <= kind_mem[w_faddr];
        r_rd_len  <= len_mem[w_faddr];
        r_rd_head <= head_mem[w_faddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lg   <= LG_RESET;
            r_free <= CW'(NUM_BLOCKS);
            r_ccnt <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_lg <= i_cfg_wr_data;
            end
            if (i_op == OP_CLEAR) begin
                r_ccnt <= r_ccnt + 1'b1;
            end
            if (i_op == OP_REL_STEP && r_rd_busy) begin
                r_free <= r_free + 1'b1;
            end
            if (i_op == OP_ALC_STEP && !r_rd_busy && r_free != '0) begin
                r_free <= r_free - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LATCH: begin
                r_cmd     <= i_command;
                r_slot    <= i_file_slot;
                r_size    <= i_req_bytes;
                r_kind    <= i_req_kind;
                r_status  <= ST_DONE;
                r_created <= 6'd0;
                r_fptr    <= '0;
            end
            OP_SCAN_NEXT: begin
                r_fptr <= r_fptr + 1'b1;
            end
            OP_CLAIM: begin
                r_created <= w_fptr_ext[5:0];
            end
            OP_NOSLOT: begin
                r_status <= ST_NO_SLOT;
            end
            OP_REJECT: begin
                r_status <= ST_NO_SPACE;
            end
            OP_EVAL: begin
                r_oldc <= w_oldc;
                r_newc <= w_newc;
                r_head <= r_rd_head;
            end
            OP_REL_INIT: begin
                r_blk <= r_head;
                r_cnt <= cap(r_oldc);
            end
            OP_WALK_GROW: begin
                r_blk <= r_head;
                r_cnt <= cap(r_oldc - 25'd1);
            end
            OP_WALK_CUT: begin
                r_blk <= r_head;
                r_cnt <= cap(r_newc - 25'd1);
            end
            OP_WALK_STEP: begin
                r_blk <= r_rd_link;
                r_cnt <= r_cnt - 1'b1;
            end
            OP_CUT: begin
                r_blk <= r_rd_link;
                r_cnt <= cap(r_oldc - r_newc);
            end
            OP_REL_STEP: begin
                r_blk <= r_rd_link;
                r_cnt <= r_cnt - 1'b1;
            end
            OP_ALC_INIT: begin
                r_bptr     <= '0;
                r_need     <= cap(r_newc - r_oldc);
                r_tail     <= r_blk;
                r_has_tail <= (r_oldc != 25'd0);
            end
            OP_ALC_STEP: begin
                if (!r_rd_busy) begin
                    r_need     <= r_need - 1'b1;
                    r_tail     <= r_bptr;
                    r_has_tail <= 1'b1;
                end
                r_bptr <= r_bptr + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_sts.cmd       = r_cmd;
        o_sts.slot_ok   = (32'(r_slot) < NUM_FILES);
        o_sts.kind_zero = (r_rd_kind == 2'd0);
        o_sts.fptr_last = (r_fptr == FW'(NUM_FILES - 1));
        o_sts.grow      = (r_newc > r_oldc);
        o_sts.shrink    = (r_newc < r_oldc);
        o_sts.oldc_zero = (r_oldc == 25'd0);
        o_sts.newc_zero = (r_newc == 25'd0);
        o_sts.too_short = ((r_newc - r_oldc) > 25'(r_free));
        o_sts.cnt_zero  = (r_cnt == '0);
        o_sts.busy      = r_rd_busy;
        o_sts.need_one  = (r_need == CW'(1));
        o_sts.bptr_last = (r_bptr == BW'(NUM_BLOCKS - 1));
        o_sts.clr_last  = (r_ccnt == CLW'(MAXN - 1));
    end

    assign o_status       = r_status;
    assign o_created_slot = r_created;
    assign o_free_count   = w_free_ext[8:0];

    a_free_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_free) <= NUM_BLOCKS)
        else $error("Free block count exceeds the number of blocks.");

    a_alloc_has_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_ALC_STEP && !r_rd_busy) |-> (r_free != '0))
        else $error("A free block was found while the free count is zero.");

    a_need_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_ALC_STEP) |-> (r_need != '0))
        else $error("Allocation step taken with no block still needed.");

endmodule
`default_nettype wire

@@ rtl/core/fbca_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Block chain allocator controller
// Sequences the clearing pass, the file table scan, chain walks, releases
// and block allocation, one request at a time.
// ---------------------------------------------------------------------------
module fbca_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_req_valid,
    output logic              o_req_ready,
    output logic              o_rsp_valid,
    input  wire               i_rsp_ready,
    input  fbca_pkg::t_dp_sts i_sts,
    output fbca_pkg::t_op     o_op
);
    import fbca_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_SCAN_CHK,
        S_SCAN_WAIT,
        S_FILE_CHK,
        S_DECIDE,
        S_WALK_RD,
        S_WALK_DO,
        S_CUT_DO,
        S_REL_RD,
        S_REL_DO,
        S_ALC_RD,
        S_ALC_DO,
        S_FIN,
        S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;
    t_op    w_op;

    always_comb begin
        n_state = r_state;
        w_op    = OP_NONE;
        case (r_state)
            S_CLEAR: begin
                w_op = OP_CLEAR;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    w_op    = OP_LATCH;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_sts.cmd == CMD_CREATE) begin
                    n_state = S_SCAN_CHK;
                end else if ((i_sts.cmd == CMD_RESIZE || i_sts.cmd == CMD_DELETE)
                             && i_sts.slot_ok) begin
                    n_state = S_FILE_CHK;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_SCAN_CHK: begin
                if (i_sts.kind_zero) begin
                    w_op    = OP_CLAIM;
                    n_state = S_RESULT;
                end else if (i_sts.fptr_last) begin
                    w_op    = OP_NOSLOT;
                    n_state = S_RESULT;
                end else begin
                    w_op    = OP_SCAN_NEXT;
                    n_state = S_SCAN_WAIT;
                end
            end
            S_SCAN_WAIT: begin
                n_state = S_SCAN_CHK;
            end
            S_FILE_CHK: begin
                if (i_sts.kind_zero) begin
                    n_state = S_RESULT;
                end else begin
                    w_op    = OP_EVAL;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.cmd == CMD_DELETE) begin
                    w_op    = OP_REL_INIT;
                    n_state = S_REL_RD;
                end else if (i_sts.grow) begin
                    if (i_sts.too_short) begin
                        w_op    = OP_REJECT;
                        n_state = S_RESULT;
                    end else if (i_sts.oldc_zero) begin
                        w_op    = OP_ALC_INIT;
                        n_state = S_ALC_RD;
                    end else begin
                        w_op    = OP_WALK_GROW;
                        n_state = S_WALK_RD;
                    end
                end else if (i_sts.shrink) begin
                    if (i_sts.newc_zero) begin
                        w_op    = OP_REL_INIT;
                        n_state = S_REL_RD;
                    end else begin
                        w_op    = OP_WALK_CUT;
                        n_state = S_WALK_RD;
                    end
                end else begin
                    n_state = S_FIN;
                end
            end
            S_WALK_RD: begin
                if (!i_sts.cnt_zero) begin
                    n_state = S_WALK_DO;
                end else if (i_sts.grow) begin
                    w_op    = OP_ALC_INIT;
                    n_state = S_ALC_RD;
                end else begin
                    n_state = S_CUT_DO;
                end
            end
            S_WALK_DO: begin
                w_op    = OP_WALK_STEP;
                n_state = S_WALK_RD;
            end
            S_CUT_DO: begin
                w_op    = OP_CUT;
                n_state = S_REL_RD;
            end
            S_REL_RD: begin
                n_state = i_sts.cnt_zero ? S_FIN : S_REL_DO;
            end
            S_REL_DO: begin
                w_op    = OP_REL_STEP;
                n_state = S_REL_RD;
            end
            S_ALC_RD: begin
                w_op    = OP_ALC_RD;
                n_state = S_ALC_DO;
            end
            S_ALC_DO: begin
                w_op = OP_ALC_STEP;
                if ((!i_sts.busy && i_sts.need_one) || i_sts.bptr_last) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_ALC_RD;
                end
            end
            S_FIN: begin
                if (i_sts.cmd == CMD_DELETE) begin
                    w_op = OP_FIN_DEL;
                end else if (i_sts.newc_zero) begin
                    w_op = OP_FIN_SHR0;
                end else begin
                    w_op = OP_FIN_LEN;
                end
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_op        = w_op;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_RESULT);

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_req_ready && o_rsp_valid))
        else $error("Request and response channels are open together.");

    a_rsp_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && i_rsp_ready) |=> o_req_ready)
        else $error("Controller did not return to idle after a response transfer.");

    a_latch_on_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op == OP_LATCH) |-> (o_req_ready && i_req_valid))
        else $error("Request latched without a request transfer.");

endmodule
`default_nettype wire
